// ===== rtl/core/lfac_pkg.sv =====
// ----------------------------------------------------------------------------
// lfac_pkg
// Shared types and constants of the fully associative LRU cache core.
// ----------------------------------------------------------------------------
package lfac_pkg;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [31:0] CNT_TOP = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] value;
  } lfac_in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
  } lfac_out_t;

endpackage

// ===== rtl/core/lfac_ram.sv =====
// ----------------------------------------------------------------------------
// lfac_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lfac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/lfac_front.sv =====
// ----------------------------------------------------------------------------
// lfac_front
// Accepts input words, drops unknown operations and queues the rest in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module lfac_front
  import lfac_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  lfac_in_t in_data,
  output logic     op_valid,
  output lfac_in_t op_word,
  input  logic     op_take
);

  lfac_in_t   q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       known;
  logic       wr;

  assign full     = (cnt_r == 2'd2);
  assign op_valid = (cnt_r != 2'd0);
  assign op_word  = q_r[rp_r];

  always_comb begin
    unique case (in_data.kind)
      KIND_LOOKUP, KIND_INSERT, KIND_CLEAR: known = 1'b1;
      default:                              known = 1'b0;
    endcase
  end

  assign wr = push && !full && known;

  always_comb begin
    wp_nxt  = wp_r ^ wr;
    rp_nxt  = rp_r ^ op_take;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, op_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= in_data;
    end
  end

endmodule

// ===== rtl/core/lfac_outq.sv =====
// ----------------------------------------------------------------------------
// lfac_outq
// Two-entry result queue between the back end and the result port.
// ----------------------------------------------------------------------------
module lfac_outq
  import lfac_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_wr,
  input  lfac_out_t res_word,
  output logic      res_space,
  output logic      empty,
  input  logic      pop,
  output lfac_out_t out_data
);

  lfac_out_t  q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd;

  assign empty     = (cnt_r == 2'd0);
  assign res_space = (cnt_r != 2'd2);
  assign out_data  = q_r[rp_r];
  assign rd        = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r ^ res_wr;
    rp_nxt  = rp_r ^ rd;
    cnt_nxt = cnt_r + {1'b0, res_wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      q_r[wp_r] <= res_word;
    end
  end

endmodule

// ===== rtl/core/lfac_back.sv =====
// ----------------------------------------------------------------------------
// lfac_back
// Sequencer that scans the entry store one entry per cycle, then performs
// the lookup, insert or clear and posts a lookup result.
// ----------------------------------------------------------------------------
module lfac_back
  import lfac_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      op_valid,
  input  lfac_in_t  op_word,
  output logic      op_take,
  input  logic      res_space,
  output logic      res_wr,
  output lfac_out_t res_word,
  output logic      busy
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] ISSUE_END = CW'(ENTRIES);
  localparam logic [IW-1:0] IDX_LAST  = IW'(ENTRIES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  lfac_in_t           op_r, op_nxt;
  logic [CW-1:0]      issue_r, issue_nxt;
  logic               dv_r, dv_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               found_r, found_nxt;
  logic [IW-1:0]      match_r, match_nxt;
  logic [31:0]        hit_val_r, hit_val_nxt;
  logic               free_r, free_nxt;
  logic [IW-1:0]      free_idx_r, free_idx_nxt;
  logic [IW-1:0]      best_idx_r, best_idx_nxt;
  logic [31:0]        best_stamp_r, best_stamp_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [31:0]        cnt_r, cnt_nxt;

  logic [IW-1:0] raddr;
  logic [31:0]   key_rd, val_rd, stamp_rd;
  logic          key_we, val_we, stamp_we;
  logic [IW-1:0] wr_idx;
  logic [31:0]   stamp_wd;
  logic [31:0]   cnt_inc;
  logic          cur_valid;

  assign raddr     = issue_r[IW-1:0];
  assign cnt_inc   = (cnt_r == CNT_TOP) ? cnt_r : cnt_r + 32'd1;
  assign cur_valid = valid_r[idx_r];
  assign busy      = (state_r != ST_IDLE);

  lfac_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(wr_idx), .wdata(op_r.key),
    .raddr(raddr), .rdata(key_rd)
  );

  lfac_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(wr_idx), .wdata(op_r.value),
    .raddr(raddr), .rdata(val_rd)
  );

  lfac_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_stamp_ram (
    .clk(clk), .we(stamp_we), .waddr(wr_idx), .wdata(stamp_wd),
    .raddr(raddr), .rdata(stamp_rd)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    issue_nxt      = issue_r;
    dv_nxt         = 1'b0;
    idx_nxt        = idx_r;
    found_nxt      = found_r;
    match_nxt      = match_r;
    hit_val_nxt    = hit_val_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    best_idx_nxt   = best_idx_r;
    best_stamp_nxt = best_stamp_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    op_take        = 1'b0;
    res_wr         = 1'b0;
    res_word       = '0;
    key_we         = 1'b0;
    val_we         = 1'b0;
    stamp_we       = 1'b0;
    wr_idx         = free_r ? free_idx_r : best_idx_r;
    stamp_wd       = cnt_r;

    unique case (state_r)
      ST_IDLE: begin
        // A lookup only starts when its result is sure to find room.
        if (op_valid && (op_word.kind != KIND_LOOKUP || res_space)) begin
          op_take   = 1'b1;
          op_nxt    = op_word;
          issue_nxt = '0;
          found_nxt = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue_r != ISSUE_END) begin
          issue_nxt = issue_r + CW'(1);
          dv_nxt    = 1'b1;
          idx_nxt   = issue_r[IW-1:0];
        end
        if (dv_r) begin
          if (cur_valid && key_rd == op_r.key && !found_r) begin
            found_nxt   = 1'b1;
            match_nxt   = idx_r;
            hit_val_nxt = val_rd;
          end
          if (!cur_valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = idx_r;
          end
          // Strict compare keeps the lowest index among equal stamps.
          if (idx_r == '0 || stamp_rd < best_stamp_r) begin
            best_idx_nxt   = idx_r;
            best_stamp_nxt = stamp_rd;
          end
          if (idx_r == IDX_LAST) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
        unique case (op_r.kind)
          KIND_LOOKUP: begin
            res_wr              = 1'b1;
            res_word.hit        = found_r;
            res_word.read_value = found_r ? hit_val_r : 32'd0;
            if (found_r) begin
              wr_idx   = match_r;
              stamp_we = 1'b1;
              stamp_wd = cnt_inc;
              cnt_nxt  = cnt_inc;
            end
          end
          KIND_INSERT: begin
            key_we            = 1'b1;
            val_we            = 1'b1;
            stamp_we          = 1'b1;
            stamp_wd          = cnt_r;
            valid_nxt[wr_idx] = 1'b1;
            cnt_nxt           = cnt_inc;
          end
          KIND_CLEAR: begin
            if (found_r) begin
              valid_nxt[match_r] = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      dv_r    <= 1'b0;
      valid_r <= '0;
      cnt_r   <= 32'd0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= dv_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    issue_r      <= issue_nxt;
    idx_r        <= idx_nxt;
    found_r      <= found_nxt;
    match_r      <= match_nxt;
    hit_val_r    <= hit_val_nxt;
    free_r       <= free_nxt;
    free_idx_r   <= free_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_stamp_r <= best_stamp_nxt;
  end

endmodule

// ===== rtl/core/lru_fully_associative_cache_core.sv =====
// ----------------------------------------------------------------------------
// lru_fully_associative_cache_core
// Fully associative key/value cache with timestamp LRU replacement.
//
//   channel   ports                      word
//   input     push, full, in_data        kind, key, value
//   result    empty, pop, out_data       hit, read_value (lookups only)
//
// In the back end each operation is taken in the idle state, then the scan
// streams the entry store through its single read port one entry per cycle,
// and the done state writes back and posts the result of a lookup.
// Reset clears the valid bits and the use counter; no clearing pass is
// needed. The front queue holds two words, so input is taken while the back
// end scans; the result queue holds two words.
// ----------------------------------------------------------------------------
module lru_fully_associative_cache_core
  import lfac_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  lfac_in_t  in_data,
  output logic      empty,
  input  logic      pop,
  output lfac_out_t out_data
);

  logic      op_valid;
  lfac_in_t  op_word;
  logic      op_take;
  logic      res_space;
  logic      res_wr;
  lfac_out_t res_word;
  logic      busy;

  lfac_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .op_valid(op_valid), .op_word(op_word), .op_take(op_take)
  );

  lfac_back #(.ENTRIES(ENTRIES)) u_back (
    .clk(clk), .rst_n(rst_n), .op_valid(op_valid), .op_word(op_word),
    .op_take(op_take), .res_space(res_space), .res_wr(res_wr),
    .res_word(res_word), .busy(busy)
  );

  lfac_outq u_outq (
    .clk(clk), .rst_n(rst_n), .res_wr(res_wr), .res_word(res_word),
    .res_space(res_space), .empty(empty), .pop(pop), .out_data(out_data)
  );

`ifndef SYNTH
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_wr |-> res_space)
    else $error("result written into a full result queue");

  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    op_take |-> (op_valid && !busy))
    else $error("operation taken while the back end is busy");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    op_take |=> busy)
    else $error("back end did not start after taking an operation");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not cleared by reset");
`endif

endmodule
